// ===== sv/crcfr_pkg.sv =====
// Package for the CRC16 frame receiver: codes, constants, pipeline types
// and the reflected CRC16 byte update. No dependencies.

package crcfr_pkg;

  localparam logic [7:0]  SYNC_FIRST    = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND   = 8'h55;
  localparam logic [15:0] CRC_SEED      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'h8408;
  localparam logic [20:0] MAX_LEN_RESET = 21'd32784;

  localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
  localparam logic [2:0] KIND_GOOD     = 3'd1;
  localparam logic [2:0] KIND_CRC_ERR  = 3'd2;
  localparam logic [2:0] KIND_LEN_ERR  = 3'd3;
  localparam logic [2:0] KIND_SYNC_ERR = 3'd4;

  // Held input item between the input register and the parser.
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } stage_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  b);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

// ===== sv/crcfr_if.sv =====
// Channel interfaces of the CRC16 frame receiver: received bytes, results
// and the configuration write. No dependencies.

interface crcfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface crcfr_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [7:0]  data_byte;
  logic [7:0]  frame_type;
  logic [31:0] frame_length;
  logic [15:0] received_crc;
  logic [15:0] computed_crc;
  logic [31:0] good_frame_count;
  logic [31:0] error_count;
  modport source (output valid, output result_kind, output data_byte, output frame_type,
                  output frame_length, output received_crc, output computed_crc,
                  output good_frame_count, output error_count, input ready);
  modport sink (input valid, input result_kind, input data_byte, input frame_type,
                input frame_length, input received_crc, input computed_crc,
                input good_frame_count, input error_count, output ready);
endinterface

interface crcfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [20:0] max_payload_length;
  modport source (output valid, output max_payload_length, input ready);
  modport sink (input valid, input max_payload_length, output ready);
endinterface

// ===== sv/crc16_frame_receiver.sv =====
// Top level of the CRC16 frame receiver.
// Depends on crcfr_pkg, the crcfr interfaces, crcfr_in_stage and crcfr_core.
//
// Usage:
//   rx  : one received serial byte per item (valid/ready).
//   res : zero or one result item per received byte: payload byte, frame
//         good, CRC error, length too large or sync error, with the frame
//         type, declared length, CRCs and the wrapping good/error counters.
//   cfg : write of max_payload_length; always ready. Write only while idle.
// Result path: an accepted byte lands in the input register; the parse logic
// loads the result register from it when no result is pending or the
// pending one is taken.
// Throughput: one byte per cycle unless a result waits on res.ready; the one-byte
// CRC update and the phase sequencer are combinational between the two registers.
// Reset (synchronous, rst high): hunting for the first sync byte, CRC at
// 0xFFFF, counters zero, max_payload_length 32784, no result pending.
// Stall: while a result waits on res.ready, one more byte is held in the
// input register; after that rx.ready drops until the result is taken.

module crc16_frame_receiver
  import crcfr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  crcfr_rx_if.sink     rx,
  crcfr_res_if.source  res,
  crcfr_cfg_if.sink    cfg
);

  stage_t item;
  logic   advance;

  crcfr_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .advance (advance),
    .item    (item)
  );

  crcfr_core u_core (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .advance (advance),
    .res     (res),
    .cfg     (cfg)
  );

endmodule

// ===== sv/crcfr_in_stage.sv =====
// Input register of the CRC16 frame receiver.
// Depends on crcfr_pkg and crcfr_rx_if.

module crcfr_in_stage
  import crcfr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  crcfr_rx_if.sink     rx,
  input  logic         advance,
  output stage_t       item
);

  stage_t held;

  assign rx.ready = !held.valid || advance;
  assign item     = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      held.valid <= 1'b1;
    end else if (advance) begin
      held.valid <= 1'b0;
    end
    if (rx.valid && rx.ready) begin
      held.rx_byte <= rx.rx_byte;
    end
  end

endmodule

// ===== sv/crcfr_core.sv =====
// Frame parser of the CRC16 frame receiver: phase sequencer, running CRC,
// counters and the result register. Depends on crcfr_pkg and the interfaces.

module crcfr_core
  import crcfr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  stage_t       item,
  output logic         advance,
  crcfr_res_if.source  res,
  crcfr_cfg_if.sink    cfg
);

  localparam logic [2:0] PH_SYNC0   = 3'd0;
  localparam logic [2:0] PH_SYNC1   = 3'd1;
  localparam logic [2:0] PH_TYPE    = 3'd2;
  localparam logic [2:0] PH_LEN     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_CRCLO   = 3'd5;
  localparam logic [2:0] PH_CRCHI   = 3'd6;

  logic [20:0] max_len;
  logic [2:0]  phase, phase_next;
  logic [7:0]  type_reg, type_reg_next;
  logic [1:0]  len_idx, len_idx_next;
  logic [31:0] len_accum, len_accum_next;
  logic [20:0] bytes_rcvd, bytes_rcvd_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  crc_lo, crc_lo_next;
  logic [31:0] good_frames, good_frames_next;
  logic [31:0] errors, errors_next;

  logic        emit;
  logic [2:0]  kind;
  logic [7:0]  o_data, o_type;
  logic [31:0] o_len;
  logic [15:0] o_rcrc, o_ccrc;
  logic [7:0]  b;
  logic [15:0] crc_upd;
  logic [15:0] rcrc;

  assign cfg.ready = 1'b1;
  assign advance   = item.valid && (!res.valid || res.ready);
  assign b         = item.rx_byte;
  assign rcrc      = {b, crc_lo};

  always_comb begin
    phase_next       = phase;
    type_reg_next    = type_reg;
    len_idx_next     = len_idx;
    len_accum_next   = len_accum;
    bytes_rcvd_next  = bytes_rcvd;
    crc_next         = crc;
    crc_lo_next      = crc_lo;
    good_frames_next = good_frames;
    errors_next      = errors;
    emit             = 1'b0;
    kind             = KIND_PAYLOAD;
    o_data           = 8'h00;
    o_type           = 8'h00;
    o_len            = 32'h0;
    o_rcrc           = 16'h0;
    o_ccrc           = 16'h0;
    crc_upd          = crc_byte((phase == PH_TYPE) ? CRC_SEED : crc, b);
    unique case (phase)
      PH_SYNC0: begin
        if (b == SYNC_FIRST) begin
          phase_next = PH_SYNC1;
        end
      end
      PH_SYNC1: begin
        if (b == SYNC_SECOND) begin
          phase_next = PH_TYPE;
        end else begin
          errors_next = errors + 32'd1;
          phase_next  = (b == SYNC_FIRST) ? PH_SYNC1 : PH_SYNC0;
          emit        = 1'b1;
          kind        = KIND_SYNC_ERR;
        end
      end
      PH_TYPE: begin
        type_reg_next  = b;
        len_idx_next   = 2'd0;
        len_accum_next = 32'h0;
        crc_next       = crc_upd;
        phase_next     = PH_LEN;
      end
      PH_LEN: begin
        len_accum_next[len_idx*8 +: 8] = b;
        crc_next     = crc_upd;
        len_idx_next = len_idx + 2'd1;
        if (len_idx == 2'd3) begin
          bytes_rcvd_next = 21'd0;
          if (len_accum_next > {11'h000, max_len}) begin
            errors_next = errors + 32'd1;
            phase_next  = PH_SYNC0;
            emit        = 1'b1;
            kind        = KIND_LEN_ERR;
            o_type      = type_reg;
            o_len       = len_accum_next;
            o_ccrc      = crc_upd;
          end else begin
            phase_next = (len_accum_next == 32'h0) ? PH_CRCLO : PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        crc_next        = crc_upd;
        bytes_rcvd_next = bytes_rcvd + 21'd1;
        if ({11'h000, bytes_rcvd_next} >= len_accum) begin
          phase_next = PH_CRCLO;
        end
        emit   = 1'b1;
        kind   = KIND_PAYLOAD;
        o_data = b;
        o_type = type_reg;
        o_len  = len_accum;
        o_ccrc = crc_upd;
      end
      PH_CRCLO: begin
        crc_lo_next = b;
        phase_next  = PH_CRCHI;
      end
      PH_CRCHI: begin
        phase_next = PH_SYNC0;
        emit       = 1'b1;
        o_type     = type_reg;
        o_len      = len_accum;
        o_rcrc     = rcrc;
        o_ccrc     = crc;
        if (rcrc == crc) begin
          good_frames_next = good_frames + 32'd1;
          kind             = KIND_GOOD;
        end else begin
          errors_next = errors + 32'd1;
          kind        = KIND_CRC_ERR;
        end
      end
      default: begin
        phase_next = PH_SYNC0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len     <= MAX_LEN_RESET;
      phase       <= PH_SYNC0;
      type_reg    <= 8'h00;
      len_idx     <= 2'd0;
      len_accum   <= 32'h0;
      bytes_rcvd  <= 21'd0;
      crc         <= CRC_SEED;
      crc_lo      <= 8'h00;
      good_frames <= 32'h0;
      errors      <= 32'h0;
      res.valid   <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        max_len <= cfg.max_payload_length;
      end
      if (advance) begin
        phase       <= phase_next;
        type_reg    <= type_reg_next;
        len_idx     <= len_idx_next;
        len_accum   <= len_accum_next;
        bytes_rcvd  <= bytes_rcvd_next;
        crc         <= crc_next;
        crc_lo      <= crc_lo_next;
        good_frames <= good_frames_next;
        errors      <= errors_next;
        res.valid   <= emit;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res.result_kind      <= kind;
      res.data_byte        <= o_data;
      res.frame_type       <= o_type;
      res.frame_length     <= o_len;
      res.received_crc     <= o_rcrc;
      res.computed_crc     <= o_ccrc;
      res.good_frame_count <= good_frames_next;
      res.error_count      <= errors_next;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench for crc16_frame_receiver: sends sync/length/CRC16 frames, broken
// sequences and noise with random idling, and checks every result item
// against a built-in predictor. Depends on crcfr_pkg and the crcfr interfaces.

import crcfr_pkg::*;

typedef enum logic [2:0] {
  HUNT_FIRST, HUNT_SECOND, TAKE_TYPE, TAKE_LENGTH, TAKE_PAYLOAD, TAKE_CRC_LO, TAKE_CRC_HI
} rx_phase_e;

typedef struct packed {
  logic [2:0]  kind;
  logic [7:0]  data;
  logic [7:0]  ftype;
  logic [31:0] flen;
  logic [15:0] rcrc;
  logic [15:0] ccrc;
  logic [31:0] good;
  logic [31:0] errs;
} report_t;

// reflected CRC16, one bit at a time
function automatic logic [15:0] crc16_x25_next(input logic [15:0] crc_in,
                                               input logic [7:0] b);
  logic [15:0] c;
  logic        fb;
  c = crc_in;
  for (int i = 0; i < 8; i++) begin
    fb = c[0] ^ b[i];
    c = c >> 1;
    if (fb) c = c ^ 16'h8408;
  end
  return c;
endfunction

class frame_checker;
  logic [20:0] max_len;
  rx_phase_e   phase;
  logic [7:0]  ftype;
  logic [1:0]  len_idx;
  logic [31:0] len;
  logic [20:0] count;
  logic [15:0] crc;
  logic [7:0]  crc_lo;
  logic [31:0] good;
  logic [31:0] errs;
  report_t     reports_due[$];
  int          fails;

  function new();
    max_len = MAX_LEN_RESET;
    phase   = HUNT_FIRST;
    ftype   = '0;
    len_idx = '0;
    len     = '0;
    count   = '0;
    crc     = CRC_SEED;
    crc_lo  = '0;
    good    = '0;
    errs    = '0;
    fails   = 0;
  endfunction

  function void post(logic [2:0] kind, logic [7:0] data, logic [7:0] t, logic [31:0] l,
                     logic [15:0] rcrc, logic [15:0] ccrc);
    report_t r;
    r.kind  = kind;
    r.data  = data;
    r.ftype = t;
    r.flen  = l;
    r.rcrc  = rcrc;
    r.ccrc  = ccrc;
    r.good  = good;
    r.errs  = errs;
    reports_due.push_back(r);
  endfunction

  function void parse_byte(logic [7:0] b);
    logic [15:0] rcrc;
    case (phase)
      HUNT_FIRST: begin
        if (b == SYNC_FIRST) phase = HUNT_SECOND;
      end
      HUNT_SECOND: begin
        if (b == SYNC_SECOND) begin
          phase = TAKE_TYPE;
        end else begin
          errs++;
          phase = (b == SYNC_FIRST) ? HUNT_SECOND : HUNT_FIRST;
          post(KIND_SYNC_ERR, '0, '0, '0, '0, '0);
        end
      end
      TAKE_TYPE: begin
        ftype   = b;
        len_idx = '0;
        len     = '0;
        crc     = crc16_x25_next(CRC_SEED, b);
        phase   = TAKE_LENGTH;
      end
      TAKE_LENGTH: begin
        len[8*len_idx +: 8] = b;
        crc = crc16_x25_next(crc, b);
        len_idx++;
        if (len_idx == 2'd0) begin
          count = '0;
          if (len > {11'd0, max_len}) begin
            errs++;
            phase = HUNT_FIRST;
            post(KIND_LEN_ERR, '0, ftype, len, '0, crc);
          end else begin
            phase = (len == 0) ? TAKE_CRC_LO : TAKE_PAYLOAD;
          end
        end
      end
      TAKE_PAYLOAD: begin
        crc = crc16_x25_next(crc, b);
        count++;
        if ({11'd0, count} >= len) phase = TAKE_CRC_LO;
        post(KIND_PAYLOAD, b, ftype, len, '0, crc);
      end
      TAKE_CRC_LO: begin
        crc_lo = b;
        phase  = TAKE_CRC_HI;
      end
      TAKE_CRC_HI: begin
        rcrc  = {b, crc_lo};
        phase = HUNT_FIRST;
        if (rcrc == crc) begin
          good++;
          post(KIND_GOOD, '0, ftype, len, rcrc, crc);
        end else begin
          errs++;
          post(KIND_CRC_ERR, '0, ftype, len, rcrc, crc);
        end
      end
      default: phase = HUNT_FIRST;
    endcase
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endfunction

  function void check_result(report_t got);
    report_t want;
    if (reports_due.size() == 0) begin
      $error("unexpected result item, kind %0d", got.kind);
      fails++;
      return;
    end
    want = reports_due.pop_front();
    compare_field("result_kind", want.kind, got.kind);
    compare_field("data_byte", want.data, got.data);
    compare_field("frame_type", want.ftype, got.ftype);
    compare_field("frame_length", want.flen, got.flen);
    compare_field("received_crc", want.rcrc, got.rcrc);
    compare_field("computed_crc", want.ccrc, got.ccrc);
    compare_field("good_frame_count", want.good, got.good);
    compare_field("error_count", want.errs, got.errs);
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT = 500000;

  logic clk;
  logic rst;
  logic steady;
  int   sent;
  int   cycles;

  crcfr_rx_if  rx ();
  crcfr_res_if res ();
  crcfr_cfg_if cfg ();

  frame_checker sb;

  crc16_frame_receiver u_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .res (res),
    .cfg (cfg)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin : sink
    report_t got;
    if (!rst && res.valid && res.ready) begin
      got.kind  = res.result_kind;
      got.data  = res.data_byte;
      got.ftype = res.frame_type;
      got.flen  = res.frame_length;
      got.rcrc  = res.received_crc;
      got.ccrc  = res.computed_crc;
      got.good  = res.good_frame_count;
      got.errs  = res.error_count;
      sb.check_result(got);
    end
    res.ready <= steady || ($urandom_range(0, 99) >= 33);
  end

  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(0, 99) < 33) begin
      rx.valid <= 1'b0;
      @(posedge clk);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
    sb.parse_byte(b);
    sent++;
  endtask

  task automatic send_frame(input logic [7:0] t, input logic [31:0] flen, input bit corrupt);
    logic [15:0] crc;
    logic [7:0]  b;
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(t);
    crc = crc16_x25_next(CRC_SEED, t);
    for (int i = 0; i < 4; i++) begin
      b = flen[8*i +: 8];
      crc = crc16_x25_next(crc, b);
      send_byte(b);
    end
    if (flen > {11'd0, sb.max_len}) return;
    for (int unsigned i = 0; i < flen; i++) begin
      b = 8'($urandom);
      crc = crc16_x25_next(crc, b);
      send_byte(b);
    end
    if (corrupt) crc = crc ^ (16'd1 << $urandom_range(0, 15));
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
  endtask

  task automatic drain();
    rx.valid <= 1'b0;
    @(posedge clk);
    while (sb.reports_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [20:0] v);
    drain();
    cfg.valid              <= 1'b1;
    cfg.max_payload_length <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    sb.max_len = v;
  endtask

  task automatic run_traffic(input int n);
    int          target;
    int          pick;
    int          top;
    logic [31:0] flen;
    logic [7:0]  b;
    target = sent + n;
    while (sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        top = (sb.max_len < 12) ? int'(sb.max_len) : 12;
        flen = $urandom_range(0, top);
        if (sb.max_len <= 64 && $urandom_range(0, 9) == 0) flen = sb.max_len;
        send_frame(8'($urandom), flen, $urandom_range(0, 99) < 20);
      end else if (pick < 80) begin
        if ($urandom_range(0, 1) == 0) flen = $urandom | 32'h8000_0000;
        else flen = {11'd0, sb.max_len} + 32'd1 + $urandom_range(0, 3);
        send_frame(8'($urandom), flen, 1'b0);
      end else if (pick < 88) begin
        send_byte(SYNC_FIRST);
        do b = 8'($urandom); while (b == SYNC_SECOND);
        if ($urandom_range(0, 2) == 0) b = SYNC_FIRST;
        send_byte(b);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          do b = 8'($urandom); while (b == SYNC_FIRST);
          send_byte(b);
        end
      end
    end
  endtask

  initial begin
    sb                     = new();
    clk                    = 1'b0;
    rst                    = 1'b1;
    steady                 = 1'b0;
    sent                   = 0;
    cycles                 = 0;
    rx.valid               = 1'b0;
    rx.rx_byte             = '0;
    res.ready              = 1'b0;
    cfg.valid              = 1'b0;
    cfg.max_payload_length = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // noise, bad second byte, resync on a repeated first sync byte
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_FIRST);
    send_byte(8'h12);
    send_byte(SYNC_FIRST);
    send_frame(8'hFF, 32'd0, 1'b0);
    send_frame(8'h00, 32'hFFFF_FFFF, 1'b0);
    send_frame(8'h80, 32'd1, 1'b1);

    write_max_len(21'd0);
    send_frame(8'($urandom), 32'd0, 1'b0);
    send_frame(8'($urandom), 32'd1, 1'b0);
    run_traffic(150);

    write_max_len(21'd1048576);
    send_frame(8'($urandom), 32'd1048577, 1'b0);
    send_frame(8'($urandom), 32'd3, 1'b0);
    run_traffic(150);

    write_max_len(21'd16);
    run_traffic(170);

    write_max_len(21'd1048575);
    run_traffic(150);

    write_max_len(21'($urandom_range(0, 1048576)));
    run_traffic(150);

    write_max_len(21'd1);
    steady = 1'b1;
    run_traffic(170);
    steady = 1'b0;

    write_max_len(21'($urandom_range(2, 64)));
    run_traffic(170);

    drain();
    if (sb.fails == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule

// ===== crc16_frame_receiver.f =====
sv/crcfr_pkg.sv
sv/crcfr_if.sv
sv/crcfr_in_stage.sv
sv/crcfr_core.sv
sv/crc16_frame_receiver.sv
tb/tb_top.sv
